[rtl/sfa_pkg.sv]
package sfa_pkg;

  localparam int FRAME_W  = 16;
  localparam int COL_W    = 8;
  localparam int PERIOD_W = 24;
  localparam int ACC_W    = 32;
  localparam int CMD_W    = 3;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 24;

  // one quotient bit per divider step
  localparam int DIV_STEPS = FRAME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY_RANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_FRAME  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd6;

  localparam logic [CFG_AW-1:0] REG_SHEET_COLUMNS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SHEET_ROWS    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FRAME_PERIOD  = 2'd2;

  localparam logic [COL_W-1:0]    COLUMNS_RST = 8'd1;
  localparam logic [COL_W-1:0]    ROWS_RST    = 8'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 24'd83333;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] elapsed;
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] range_length;
    logic [FRAME_W-1:0] frame_number;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]   cell_column;
    logic [COL_W-1:0]   cell_row;
    logic [FRAME_W-1:0] current_frame;
    logic               is_playing;
    logic               range_error;
  } out_word_t;

endpackage

[rtl/sprite_frame_animator_top.sv]
// Sprite-sheet frame animation timer.
// Input channel (in_valid / in_stall / in_data): one command word per item
// (tick, play, play_range, pause, stop, set_frame, restart). Each accepted
// word yields exactly one result word on the output channel
// (out_valid / out_stall / out_data): current frame, its sheet column and row,
// the playing flag and the range error flag.
// The command updates the timer state in the cycle it is accepted; the cell
// column and row then come from a bit-serial restoring divider that produces
// one quotient bit per cycle. The result is registered into out_data, and a
// new word can be taken in the same cycle that the result appears there; no
// new word is taken while the divider is busy with the last one.
// in_stall is high while the divider runs or holds its finished result. The
// result register frees the input side: a new word is accepted while a result
// waits; if the next result is ready before the old one is taken, the divider
// holds until out_stall drops. The user must write configuration (cfg_we /
// cfg_addr / cfg_wdata) while idle only; the block itself does not enforce it.
// Synchronous reset (rst_n low) restores the register defaults, stops play,
// clears the accumulator and frame, and empties the result register.
module sprite_frame_animator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sfa_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sfa_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [sfa_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [sfa_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic [sfa_pkg::COL_W-1:0]    cols_r, cols_nxt;
  logic [sfa_pkg::COL_W-1:0]    rows_r, rows_nxt;
  logic [sfa_pkg::PERIOD_W-1:0] period_r, period_nxt;

  logic [sfa_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [sfa_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [sfa_pkg::FRAME_W-1:0] start_r, start_nxt;
  logic [sfa_pkg::FRAME_W:0]   nframes_r, nframes_nxt;
  logic                        playing_r, playing_nxt;
  logic                        err_r, err_nxt;

  logic                        state_r, state_nxt;
  logic [sfa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sfa_pkg::FRAME_W-1:0] quo_r, quo_nxt;
  logic [sfa_pkg::COL_W-1:0]   rem_r, rem_nxt;
  logic [sfa_pkg::COL_W-1:0]   div_r, div_nxt;

  logic                        out_valid_r, out_valid_nxt;
  sfa_pkg::out_word_t          out_data_r, out_data_nxt;

  logic                        accept;
  logic                        div_done;
  logic                        load_out;
  logic [sfa_pkg::COL_W-1:0]   eff_cols;
  logic [sfa_pkg::FRAME_W-1:0] frames_total;
  logic [sfa_pkg::ACC_W:0]     acc_sum;
  logic [sfa_pkg::ACC_W-1:0]   acc_sat;
  logic [sfa_pkg::FRAME_W:0]   frame_inc;
  logic [sfa_pkg::FRAME_W+1:0] range_end;
  logic [sfa_pkg::FRAME_W:0]   range_top;
  logic [sfa_pkg::COL_W:0]     rem_shift;
  logic                        rem_ge;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r == ST_BUSY);
  assign div_done = (cnt_r == sfa_pkg::CNT_W'(sfa_pkg::DIV_STEPS));
  assign load_out = (state_r == ST_BUSY) && div_done && (!out_valid_r || !out_stall);

  assign eff_cols     = (cols_r == '0) ? sfa_pkg::COL_W'(1) : cols_r;
  assign frames_total = {{(sfa_pkg::FRAME_W - sfa_pkg::COL_W){1'b0}}, eff_cols}
                      * {{(sfa_pkg::FRAME_W - sfa_pkg::COL_W){1'b0}}, rows_r};

  assign acc_sum   = {1'b0, acc_r} + {{(sfa_pkg::ACC_W - sfa_pkg::FRAME_W + 1){1'b0}},
                                       in_data.elapsed};
  assign acc_sat   = acc_sum[sfa_pkg::ACC_W] ? '1 : acc_sum[sfa_pkg::ACC_W-1:0];
  assign frame_inc = {1'b0, frame_r} + (sfa_pkg::FRAME_W+1)'(1);
  assign range_end = {2'b00, start_r} + {1'b0, nframes_r};
  assign range_top = {1'b0, in_data.first_frame} + {1'b0, in_data.range_length};

  // config registers
  always_comb begin
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    period_nxt = period_r;
    if (cfg_we) begin
      case (cfg_addr)
        sfa_pkg::REG_SHEET_COLUMNS: cols_nxt   = cfg_wdata[sfa_pkg::COL_W-1:0];
        sfa_pkg::REG_SHEET_ROWS:    rows_nxt   = cfg_wdata[sfa_pkg::COL_W-1:0];
        sfa_pkg::REG_FRAME_PERIOD:  period_nxt = cfg_wdata[sfa_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode, applied at accept
  always_comb begin
    acc_nxt     = acc_r;
    frame_nxt   = frame_r;
    start_nxt   = start_r;
    nframes_nxt = nframes_r;
    playing_nxt = playing_r;
    err_nxt     = err_r;
    if (accept) begin
      err_nxt = 1'b0;
      case (in_data.command)
        sfa_pkg::CMD_TICK: begin
          if (playing_r) begin
            if (acc_sat >= {{(sfa_pkg::ACC_W - sfa_pkg::PERIOD_W){1'b0}}, period_r}) begin
              acc_nxt = '0;
              if ({1'b0, frame_inc} >= range_end) frame_nxt = start_r;
              else frame_nxt = frame_inc[sfa_pkg::FRAME_W-1:0];
            end else begin
              acc_nxt = acc_sat;
            end
          end
        end
        sfa_pkg::CMD_PLAY: begin
          if (!playing_r) begin
            start_nxt   = '0;
            nframes_nxt = {1'b0, frames_total};
            playing_nxt = 1'b1;
            frame_nxt   = '0;
            acc_nxt     = '0;
          end
        end
        sfa_pkg::CMD_PLAY_RANGE: begin
          if (!playing_r) begin
            if (range_top > {1'b0, frames_total}) begin
              err_nxt = 1'b1;
            end else begin
              start_nxt   = in_data.first_frame;
              nframes_nxt = {1'b0, in_data.range_length};
              playing_nxt = 1'b1;
              frame_nxt   = in_data.first_frame;
              acc_nxt     = '0;
            end
          end
        end
        sfa_pkg::CMD_PAUSE: playing_nxt = 1'b0;
        sfa_pkg::CMD_STOP: begin
          playing_nxt = 1'b0;
          frame_nxt   = start_r;
        end
        sfa_pkg::CMD_SET_FRAME: begin
          if (in_data.frame_number >= frames_total) err_nxt = 1'b1;
          else frame_nxt = in_data.frame_number;
        end
        sfa_pkg::CMD_RESTART: begin
          frame_nxt = start_r;
          acc_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle, MSB first
  assign rem_shift = {rem_r, quo_r[sfa_pkg::FRAME_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    if (accept) begin
      state_nxt = ST_BUSY;
      cnt_nxt   = '0;
      quo_nxt   = frame_nxt;
      rem_nxt   = '0;
      div_nxt   = eff_cols;
    end else if (state_r == ST_BUSY) begin
      if (!div_done) begin
        cnt_nxt = cnt_r + sfa_pkg::CNT_W'(1);
        quo_nxt = {quo_r[sfa_pkg::FRAME_W-2:0], rem_ge};
        rem_nxt = rem_ge ? sfa_pkg::COL_W'(rem_shift - {1'b0, div_r})
                         : rem_shift[sfa_pkg::COL_W-1:0];
      end else if (load_out) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.cell_column   = rem_r;
      out_data_nxt.cell_row      = quo_r[sfa_pkg::COL_W-1:0];
      out_data_nxt.current_frame = frame_r;
      out_data_nxt.is_playing    = playing_r;
      out_data_nxt.range_error   = err_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= sfa_pkg::COLUMNS_RST;
      rows_r      <= sfa_pkg::ROWS_RST;
      period_r    <= sfa_pkg::PERIOD_RST;
      acc_r       <= '0;
      frame_r     <= '0;
      start_r     <= '0;
      nframes_r   <= '0;
      playing_r   <= 1'b0;
      err_r       <= 1'b0;
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      period_r    <= period_nxt;
      acc_r       <= acc_nxt;
      frame_r     <= frame_nxt;
      start_r     <= start_nxt;
      nframes_r   <= nframes_nxt;
      playing_r   <= playing_nxt;
      err_r       <= err_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_BUSY) && (cnt_r == '0))
    else $error("accepted word did not start the divider");

  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_BUSY) && $past(div_done))
    else $error("result shown without a finished divide");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sfa_pkg::CNT_W'(sfa_pkg::DIV_STEPS))
    else $error("divider step count out of range");

endmodule
